@@ src/bwlp_pkg.sv @@
// package for the fifth-order butterworth lowpass block
// holds widths, fixed-point constants, sequencer state and operation codes
// no dependencies
package bwlp_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int HISTORY_WIDTH_DEF = 32;

  localparam int SRATE_W = 18;
  localparam int CUT_W   = 17;
  localparam logic [SRATE_W-1:0] SRATE_RST = 18'd48000;

  // q.26 working format, coefficients fit in CQ_W signed bits
  localparam int QF    = 26;
  localparam int CQ_W  = 41;
  localparam int CE_W  = CQ_W + 4;

  localparam logic [34:0] TWOPI_Q32 = 35'd26986075409;
  localparam logic signed [CQ_W-1:0] CONST_R = 41'sd217168846;
  localparam logic signed [CQ_W-1:0] CONST_K = 41'sd1405546295;

  // numerator width of the omega division: cutoff * 2pi plus half the divisor
  localparam int WNUM_W = 53;

  // multiplier digit size on the coefficient operand
  localparam int MUL_DW = 14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } bwlp_state_t;

  typedef enum logic [3:0] {
    OP_WNUM,
    OP_W2,
    OP_W3,
    OP_W4,
    OP_W5,
    OP_RP,
    OP_RM,
    OP_KQ,
    OP_KN,
    OP_FWD,
    OP_FB1,
    OP_FB2,
    OP_FB3,
    OP_FB4,
    OP_FB5
  } bwlp_op_t;

endpackage

@@ src/bwlp_ifs.sv @@
// valid/ready channel interfaces for sample input, filtered output and config
// depends on bwlp_pkg for the fixed field widths
interface bwlp_in_if #(parameter int SW = bwlp_pkg::SAMPLE_WIDTH_DEF);
  logic                           valid;
  logic                           ready;
  logic signed [SW-1:0]           sample_in;
  logic [bwlp_pkg::CUT_W-1:0]     cutoff_hz;
  modport source (output valid, output sample_in, output cutoff_hz, input ready);
  modport sink (input valid, input sample_in, input cutoff_hz, output ready);
endinterface

interface bwlp_out_if #(parameter int SW = bwlp_pkg::SAMPLE_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] filtered_sample;
  modport source (output valid, output filtered_sample, input ready);
  modport sink (input valid, input filtered_sample, output ready);
endinterface

interface bwlp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bwlp_pkg::SRATE_W-1:0] sample_rate;
  modport source (output valid, output sample_rate, input ready);
  modport sink (input valid, input sample_rate, output ready);
endinterface

@@ src/bwlp_mul.sv @@
// shared signed multiplier, one digit of the b operand per cycle
// depends on bwlp_pkg
module bwlp_mul #(
  parameter int A_W = bwlp_pkg::CQ_W,
  parameter int B_W = bwlp_pkg::CQ_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [A_W-1:0]  a,
  input  logic signed [B_W-1:0]  b,
  output logic                   done,
  output logic signed [A_W+B_W-1:0] p
);
  import bwlp_pkg::*;

  localparam int DW    = MUL_DW;
  localparam int ND    = (B_W + DW - 1) / DW;
  localparam int BM_W  = ND * DW;
  localparam int M_W   = A_W + BM_W;
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(ND + 1);

  logic [A_W-1:0]   am_r;
  logic [BM_W-1:0]  bm_r;
  logic             neg_r;
  logic [M_W-1:0]   acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             fin_r;
  logic             done_r;
  logic signed [P_W-1:0] p_r;
  logic [A_W+DW-1:0] dprod;
  logic [B_W-1:0]   b_mag;

  assign dprod = (A_W+DW)'(am_r) * (A_W+DW)'(bm_r[BM_W-1 -: DW]);
  assign b_mag = b[B_W-1] ? B_W'(-b) : B_W'(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a[A_W-1] ? A_W'(-a) : A_W'(a);
      bm_r  <= BM_W'(b_mag);
      neg_r <= a[A_W-1] ^ b[B_W-1];
      acc_r <= '0;
    end else if (busy_r) begin
      // most significant digit first
      acc_r <= (acc_r << DW) + M_W'(dprod);
      bm_r  <= bm_r << DW;
    end else if (fin_r) begin
      p_r <= neg_r ? -$signed(acc_r[P_W-1:0]) : $signed(acc_r[P_W-1:0]);
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

@@ src/bwlp_div.sv @@
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on nothing but its parameters
module bwlp_div #(
  parameter int NUM_W = 88,
  parameter int DEN_W = 41
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  input  logic [$clog2(NUM_W+1)-1:0]    steps,
  output logic                          done,
  output logic [NUM_W-1:0]              quo,
  output logic [DEN_W-1:0]              rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem2;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign rem2 = {rem_r, n_r[NUM_W-1]};
  assign ge   = rem2 >= {1'b0, den_r};
  assign diff = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      q_r   <= '0;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      n_r   <= n_r << 1;
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

@@ src/butterworth_lowpass5_variable_cutoff.sv @@
// from input transaction to result valid: the omega product and the omega division, then
// 14 more products on the shared multiplier (15 in all), the output division, the
// history update in ST_FIN and the output load in ST_OUT
// one sample at a time; a result not yet taken holds the next sample in ST_OUT
// synchronous active-low reset clears histories, sample_rate to 48000, no result pending.
// uses bwlp_pkg, bwlp_ifs, bwlp_mul and bwlp_div
module butterworth_lowpass5_variable_cutoff #(
  parameter int SAMPLE_WIDTH  = bwlp_pkg::SAMPLE_WIDTH_DEF,
  parameter int HISTORY_WIDTH = bwlp_pkg::HISTORY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bwlp_in_if.sink    in_ch,
  bwlp_out_if.source out_ch,
  bwlp_cfg_if.sink   cfg_ch
);
  import bwlp_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int HW     = HISTORY_WIDTH;
  localparam int YE     = (HW - SW) / 2;
  localparam int XSUM_W = SW + 5;
  localparam int XS_W   = XSUM_W + YE;
  localparam int OPA_T  = (HW > XS_W) ? HW : XS_W;
  localparam int OPA_W  = (OPA_T > CQ_W) ? OPA_T : CQ_W;
  localparam int PW     = OPA_W + CQ_W;
  localparam int ACC_W  = PW + 3;
  localparam int SCNT_W = $clog2(ACC_W + 1);
  localparam logic signed [PW-1:0] MQ_RND = PW'(1) <<< (QF - 1);
  localparam logic signed [HW:0] Y_RND = (HW+1)'((1 << YE) >> 1);
  localparam logic signed [HW:0] O_MAX = (HW+1)'((1 << (SW - 1)) - 1);
  localparam logic signed [HW:0] O_MIN = -O_MAX - (HW+1)'(1);
  localparam logic [ACC_W-1:0] LIM = ACC_W'(1) << (HW - 1);

  bwlp_state_t state_r, state_nxt;
  bwlp_op_t    op_r;

  logic [SRATE_W-1:0] srate_r;
  logic signed [SW-1:0] x_r;
  logic [CUT_W-1:0] fc_r;
  logic signed [CQ_W-1:0] w_r, w2_r, w3_r, w4_r, w5_r, rp_r, rm_r, kq_r, kn_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] qr_r;
  logic neg_r;
  logic signed [SW-1:0] xh_r [5];
  logic signed [HW-1:0] yh_r [5];
  logic out_valid_r;
  logic signed [SW-1:0] out_data_r;

  logic mul_start, mul_done, div_start, div_done;
  logic signed [OPA_W-1:0] opa;
  logic signed [CQ_W-1:0]  opb;
  logic signed [PW-1:0]    mul_p;
  logic signed [PW-1:0]    mq_full;
  logic [ACC_W-1:0] div_num, div_quo;
  logic [CQ_W-1:0]  div_den, div_rem;
  logic [SCNT_W-1:0] div_steps;

  logic [SRATE_W-1:0] fs_eff;
  logic [CUT_W-1:0] half, cut_lo, fc_cl;
  logic [WNUM_W-1:0] wnum;

  logic signed [CE_W-1:0] we, w2e, w3e, w4e, w5e, rpe, rme, kqe, kne, one_e;
  logic signed [CE_W-1:0] pe, me, qqe, nne;
  logic signed [CE_W-1:0] ca_e, cb_e, cc_e, cd_e, ce_e, cf_e;
  logic signed [CQ_W-1:0] ca, cb, cc, cd, ce, cf;

  logic signed [XSUM_W-1:0] s03, s12, xsum;
  logic signed [XS_W-1:0] xs;
  logic [HW-1:0] y_mag;
  logic signed [HW-1:0] y_new;
  logic signed [HW:0] o_full;
  logic signed [SW-1:0] o_sat;

  // clamps on sample rate and cutoff
  assign fs_eff = (srate_r < SRATE_W'(2)) ? SRATE_W'(2) : srate_r;
  assign half   = fs_eff[SRATE_W-1:1];
  assign cut_lo = (in_ch.cutoff_hz == '0) ? CUT_W'(1) : in_ch.cutoff_hz;
  assign fc_cl  = (cut_lo > half) ? half : cut_lo;

  // bilinear coefficients from the q.26 powers of omega
  always_comb begin
    we    = CE_W'(w_r);
    w2e   = CE_W'(w2_r);
    w3e   = CE_W'(w3_r);
    w4e   = CE_W'(w4_r);
    w5e   = CE_W'(w5_r);
    rpe   = CE_W'(rp_r);
    rme   = CE_W'(rm_r);
    kqe   = CE_W'(kq_r);
    kne   = CE_W'(kn_r);
    one_e = CE_W'(1) <<< QF;
    pe    = w4e + (we <<< 3);
    me    = w4e - (we <<< 3);
    qqe   = w3e + (w2e <<< 1);
    nne   = w3e - (w2e <<< 1);
    ca_e  = w5e + (rpe <<< 1) + kqe + (one_e <<< 5);
    cb_e  = (w5e <<< 2) + w5e + (rme <<< 2) + (rme <<< 1) + kne
            - (one_e <<< 7) - (one_e <<< 5);
    cc_e  = (w5e <<< 3) + (w5e <<< 1) + (rpe <<< 2) - (kqe <<< 1)
            + (one_e <<< 8) + (one_e <<< 6);
    cd_e  = (w5e <<< 3) + (w5e <<< 1) - (rme <<< 2) - (kne <<< 1)
            - (one_e <<< 8) - (one_e <<< 6);
    ce_e  = (w5e <<< 2) + w5e - (rpe <<< 2) - (rpe <<< 1) + kqe
            + (one_e <<< 7) + (one_e <<< 5);
    cf_e  = w5e - (rme <<< 1) + kne - (one_e <<< 5);
    ca    = ca_e[CQ_W-1:0];
    cb    = cb_e[CQ_W-1:0];
    cc    = cc_e[CQ_W-1:0];
    cd    = cd_e[CQ_W-1:0];
    ce    = ce_e[CQ_W-1:0];
    cf    = cf_e[CQ_W-1:0];
  end

  // binomial numerator taps, scaled up to the history format
  always_comb begin
    s03  = XSUM_W'(xh_r[0]) + XSUM_W'(xh_r[3]);
    s12  = XSUM_W'(xh_r[1]) + XSUM_W'(xh_r[2]);
    xsum = XSUM_W'(x_r) + (s03 <<< 2) + s03 + (s12 <<< 3) + (s12 <<< 1)
           + XSUM_W'(xh_r[4]);
    xs   = XS_W'(xsum) <<< YE;
  end

  // operand selection for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      OP_WNUM: begin
        opa = OPA_W'(TWOPI_Q32);
        opb = CQ_W'(fc_r);
      end
      OP_W2: begin
        opa = OPA_W'(w_r);
        opb = w_r;
      end
      OP_W3: begin
        opa = OPA_W'(w2_r);
        opb = w_r;
      end
      OP_W4: begin
        opa = OPA_W'(w2_r);
        opb = w2_r;
      end
      OP_W5: begin
        opa = OPA_W'(w2_r);
        opb = w3_r;
      end
      OP_RP: begin
        opa = OPA_W'(CONST_R);
        opb = pe[CQ_W-1:0];
      end
      OP_RM: begin
        opa = OPA_W'(CONST_R);
        opb = me[CQ_W-1:0];
      end
      OP_KQ: begin
        opa = OPA_W'(CONST_K);
        opb = qqe[CQ_W-1:0];
      end
      OP_KN: begin
        opa = OPA_W'(CONST_K);
        opb = nne[CQ_W-1:0];
      end
      OP_FWD: begin
        opa = OPA_W'(xs);
        opb = w5_r;
      end
      OP_FB1: begin
        opa = OPA_W'(yh_r[0]);
        opb = cb;
      end
      OP_FB2: begin
        opa = OPA_W'(yh_r[1]);
        opb = cc;
      end
      OP_FB3: begin
        opa = OPA_W'(yh_r[2]);
        opb = cd;
      end
      OP_FB4: begin
        opa = OPA_W'(yh_r[3]);
        opb = ce;
      end
      OP_FB5: begin
        opa = OPA_W'(yh_r[4]);
        opb = cf;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mq_full = (mul_p + MQ_RND) >>> QF;

  // divider operands: omega division is left-aligned so only WNUM_W steps run
  always_comb begin
    wnum = acc_r[WNUM_W-1:0] + (WNUM_W'(fs_eff) << 5);
    if (op_r == OP_WNUM) begin
      div_num   = {wnum, {(ACC_W-WNUM_W){1'b0}}};
      div_den   = CQ_W'({fs_eff, 6'b0});
      div_steps = SCNT_W'(WNUM_W);
    end else begin
      div_num   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
      div_den   = ca[CQ_W-1:0];
      div_steps = SCNT_W'(ACC_W);
    end
  end

  // saturate the rounded quotient into the history range
  always_comb begin
    if (neg_r) begin
      y_mag = (qr_r > LIM) ? LIM[HW-1:0] : qr_r[HW-1:0];
      y_new = -$signed(y_mag);
    end else begin
      y_mag = (qr_r > LIM - 1'b1) ? HW'(LIM - 1'b1) : qr_r[HW-1:0];
      y_new = $signed(y_mag);
    end
  end

  // output rounding shift and saturation
  always_comb begin
    o_full = ((HW+1)'(yh_r[0]) + Y_RND) >>> YE;
    if (o_full > O_MAX) begin
      o_sat = O_MAX[SW-1:0];
    end else if (o_full < O_MIN) begin
      o_sat = O_MIN[SW-1:0];
    end else begin
      o_sat = o_full[SW-1:0];
    end
  end

  bwlp_mul #(
    .A_W (OPA_W),
    .B_W (CQ_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .p     (mul_p)
  );

  bwlp_div #(
    .NUM_W (ACC_W),
    .DEN_W (CQ_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = (op_r == OP_WNUM || op_r == OP_FB5) ? ST_DSTART : ST_ISSUE;
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (op_r == OP_WNUM) ? ST_ISSUE : ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control, config and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srate_r     <= SRATE_RST;
      op_r        <= OP_WNUM;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        srate_r <= cfg_ch.sample_rate;
      end
      if (state_r == ST_IDLE && in_ch.valid) begin
        op_r <= OP_WNUM;
      end else if (state_r == ST_MUL && mul_done && op_r != OP_WNUM && op_r != OP_FB5) begin
        op_r <= bwlp_op_t'(op_r + 4'd1);
      end else if (state_r == ST_DIV && div_done && op_r == OP_WNUM) begin
        op_r <= OP_W2;
      end
      if (state_r == ST_FIN) begin
        xh_r[0] <= x_r;
        yh_r[0] <= y_new;
        for (int i = 1; i < 5; i++) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers of one sample
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      x_r  <= in_ch.sample_in;
      fc_r <= fc_cl;
    end
    if (state_r == ST_MUL && mul_done) begin
      case (op_r)
        OP_WNUM: acc_r <= ACC_W'(mul_p);
        OP_W2:   w2_r <= mq_full[CQ_W-1:0];
        OP_W3:   w3_r <= mq_full[CQ_W-1:0];
        OP_W4:   w4_r <= mq_full[CQ_W-1:0];
        OP_W5:   w5_r <= mq_full[CQ_W-1:0];
        OP_RP:   rp_r <= mq_full[CQ_W-1:0];
        OP_RM:   rm_r <= mq_full[CQ_W-1:0];
        OP_KQ:   kq_r <= mq_full[CQ_W-1:0];
        OP_KN:   kn_r <= mq_full[CQ_W-1:0];
        OP_FWD:  acc_r <= ACC_W'(mul_p);
        default: acc_r <= acc_r - ACC_W'(mul_p);
      endcase
    end
    if (state_r == ST_DSTART) begin
      neg_r <= acc_r[ACC_W-1];
    end
    if (state_r == ST_DIV && div_done) begin
      if (op_r == OP_WNUM) begin
        w_r <= div_quo[CQ_W-1:0];
      end else begin
        // round half away from zero on the magnitude
        qr_r <= div_quo + ACC_W'(({1'b0, div_rem, 1'b0}) >= {2'b0, ca[CQ_W-1:0]});
      end
    end
    if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      out_data_r <= o_sat;
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.filtered_sample = out_data_r;

endmodule
